@@ src/token_credit_distributor_unit_macros.svh @@
// Assertion helpers shared by the project.
`ifndef TOKEN_CREDIT_DISTRIBUTOR_UNIT_MACROS_SVH
`define TOKEN_CREDIT_DISTRIBUTOR_UNIT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define TCD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define TCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/tcd_pkg.sv @@
package tcd_pkg;

   typedef enum logic [2:0] {
      CMD_INIT    = 3'd0,
      CMD_REQUEST = 3'd1,
      CMD_REL_ONE = 3'd2,
      CMD_REL_MANY = 3'd3,
      CMD_DIST    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_GRANT   = 2'd2,
      ST_NONE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_MIN_CHUNK  = 2'd0,
      REG_MAX_CHUNK  = 2'd1,
      REG_MAX_TOKENS = 2'd2
   } reg_index_type;

   localparam logic [15:0] MIN_CHUNK_RESET  = 16'd1;
   localparam logic [15:0] MAX_CHUNK_RESET  = 16'd8;
   localparam logic [15:0] MAX_TOKENS_RESET = 16'd64;
   localparam logic [15:0] POOL_MAX         = 16'hFFFF;

   typedef struct packed {
      logic [15:0] eff_min;
      logic [15:0] eff_max;
      logic        pool_load;
      logic [15:0] pool_value;
   } cfg_type;

   typedef struct packed {
      logic        we_txq;
      logic        we_chunk;
      logic        we_req;
      logic        we_gr;
      logic [7:0]  txq;
      logic [15:0] chunk;
      logic [15:0] req;
      logic [15:0] gr;
   } tbl_wr_type;

   typedef struct packed {
      logic [7:0]  txq;
      logic [15:0] chunk;
      logic [15:0] req;
      logic [15:0] gr;
   } tbl_rd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  remote_res;
      logic [7:0]  tx_queue_res;
      logic [15:0] granted;
      logic        last;
   } rsp_type;

endpackage

@@ src/tcd_if.sv @@
interface tcd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [4:0]  remote;
   logic [7:0]  tx_queue;
   logic [15:0] count;
   modport source (output valid, cmd, remote, tx_queue, count, input ready);
   modport sink (input valid, cmd, remote, tx_queue, count, output ready);
endinterface

interface tcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  remote_res;
   logic [7:0]  tx_queue_res;
   logic [15:0] granted;
   logic        last;
   modport source (output valid, status, remote_res, tx_queue_res, granted, last,
                   input ready);
   modport sink (input valid, status, remote_res, tx_queue_res, granted, last,
                 output ready);
endinterface

interface tcd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/tcd_table.sv @@
module tcd_table
   import tcd_pkg::*;
#(
   parameter int NUM_REMOTES = 32,
   localparam int IW = $clog2(NUM_REMOTES)
) (
   input  logic          clock,
   input  logic [IW-1:0] addr,
   input  tbl_wr_type    wr,
   output tbl_rd_type    rd_ff
);

   logic [7:0]  txq_mem   [NUM_REMOTES];
   logic [15:0] chunk_mem [NUM_REMOTES];
   logic [15:0] req_mem   [NUM_REMOTES];
   logic [15:0] gr_mem    [NUM_REMOTES];

   always_ff @(posedge clock) begin
      if (wr.we_txq) begin
         txq_mem[addr] <= wr.txq;
      end
      if (wr.we_chunk) begin
         chunk_mem[addr] <= wr.chunk;
      end
      if (wr.we_req) begin
         req_mem[addr] <= wr.req;
      end
      if (wr.we_gr) begin
         gr_mem[addr] <= wr.gr;
      end
      rd_ff.txq   <= txq_mem[addr];
      rd_ff.chunk <= chunk_mem[addr];
      rd_ff.req   <= req_mem[addr];
      rd_ff.gr    <= gr_mem[addr];
   end

endmodule

@@ src/tcd_fifo.sv @@
module tcd_fifo
   import tcd_pkg::*;
#(
   parameter int NUM_REMOTES = 32,
   localparam int IW = $clog2(NUM_REMOTES)
) (
   input  logic          clock,
   input  logic [IW-1:0] raddr,
   input  logic          we,
   input  logic [IW-1:0] waddr,
   input  logic [IW-1:0] wdata,
   output logic [IW-1:0] rdata_ff
);

   logic [IW-1:0] mem [NUM_REMOTES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

@@ src/tcd_ctrl.sv @@
`include "token_credit_distributor_unit_macros.svh"

module tcd_ctrl
   import tcd_pkg::*;
#(
   parameter int NUM_REMOTES = 32,
   localparam int IW = $clog2(NUM_REMOTES),
   localparam int CW = $clog2(NUM_REMOTES + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [4:0]  req_remote,
   input  logic [7:0]  req_tx_queue,
   input  logic [15:0] req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_CRD   = 12'b000000000010,
      S_CEX   = 12'b000000000100,
      S_DFIFO = 12'b000000001000,
      S_DENT  = 12'b000000010000,
      S_DRD   = 12'b000000100000,
      S_DEV   = 12'b000001000000,
      S_EFIFO = 12'b000010000000,
      S_EENT  = 12'b000100000000,
      S_ERD   = 12'b001000000000,
      S_EEV   = 12'b010000000000,
      S_FIN   = 12'b100000000000
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [7:0]    txq_ff, txq_in;
   logic [15:0]   count_ff, count_in;
   logic          inrange_ff, inrange_in;
   logic          known_ff, known_in;
   logic [IW-1:0] ent_ff, ent_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] wcnt_ff, wcnt_in;
   logic          moved_ff, moved_in;
   logic [15:0]   pool_ff, pool_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [IW-1:0] pend_ent_ff, pend_ent_in;
   logic [7:0]    pend_txq_ff, pend_txq_in;
   logic [15:0]   pend_gr_ff, pend_gr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          valid_ff [NUM_REMOTES];
   logic          queued_ff [NUM_REMOTES];

   tbl_wr_type    tbl_wr;
   tbl_rd_type    tbl_rd;
   logic          fifo_we;
   logic [IW-1:0] fifo_waddr, fifo_wdata, fifo_rd;

   logic          out_free, req_fire, set_valid, set_queued, clr_queued;
   logic          ok, last_idx, has;
   logic [15:0]   pool_dec, chunk_nx;
   logic [16:0]   pool_sum;
   logic [IW-1:0] ri;

   tcd_table #(.NUM_REMOTES(NUM_REMOTES)) u_table (
      .clock (clock),
      .addr  (ent_ff),
      .wr    (tbl_wr),
      .rd_ff (tbl_rd)
   );

   tcd_fifo #(.NUM_REMOTES(NUM_REMOTES)) u_fifo (
      .clock    (clock),
      .raddr    (idx_ff),
      .we       (fifo_we),
      .waddr    (fifo_waddr),
      .wdata    (fifo_wdata),
      .rdata_ff (fifo_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign ri        = IW'(req_remote);
   assign last_idx  = ((CW'(idx_ff) + CW'(1)) == wcnt_ff);
   assign ok        = (tbl_rd.gr < tbl_rd.req) && (tbl_rd.gr < tbl_rd.chunk);
   assign has       = (tbl_rd.gr != 16'd0);
   assign pool_dec  = ok ? pool_ff - 16'd1 : pool_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      txq_in        = txq_ff;
      count_in      = count_ff;
      inrange_in    = inrange_ff;
      known_in      = known_ff;
      ent_in        = ent_ff;
      idx_in        = idx_ff;
      keep_in       = keep_ff;
      wcnt_in       = wcnt_ff;
      moved_in      = moved_ff;
      pool_in       = pool_ff;
      pend_valid_in = pend_valid_ff;
      pend_ent_in   = pend_ent_ff;
      pend_txq_in   = pend_txq_ff;
      pend_gr_in    = pend_gr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      tbl_wr        = '0;
      fifo_we       = 1'b0;
      fifo_waddr    = IW'(wcnt_ff);
      fifo_wdata    = ent_ff;
      set_valid     = 1'b0;
      set_queued    = 1'b0;
      clr_queued    = 1'b0;
      chunk_nx      = tbl_rd.chunk;
      pool_sum      = {1'b0, pool_ff} + {1'b0, count_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_cmd;
               txq_in     = req_tx_queue;
               count_in   = req_count;
               inrange_in = (32'(req_remote) < NUM_REMOTES);
               known_in   = (32'(req_remote) < NUM_REMOTES) && valid_ff[ri];
               ent_in     = ri;
               idx_in     = '0;
               keep_in    = '0;
               moved_in   = 1'b0;
               pend_valid_in = 1'b0;
               if (req_cmd != CMD_DIST) begin
                  state_in = S_CRD;
               end else if (wcnt_ff == '0) begin
                  state_in = S_FIN;
               end else if (pool_ff == 16'd0) begin
                  state_in = S_EFIFO;
               end else begin
                  state_in = S_DFIFO;
               end
            end
         end
         S_CRD: begin
            state_in = S_CEX;
         end
         S_CEX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: ST_DONE, remote_res: 5'd0, tx_queue_res: 8'd0,
                          granted: 16'd0, last: 1'b1};
               state_in = S_IDLE;
               case (cmd_ff)
                  CMD_INIT: begin
                     if (!inrange_ff) begin
                        rsp_in.status = ST_UNKNOWN;
                     end else begin
                        set_valid       = 1'b1;
                        tbl_wr.we_txq   = 1'b1;
                        tbl_wr.we_chunk = 1'b1;
                        tbl_wr.we_req   = 1'b1;
                        tbl_wr.we_gr    = 1'b1;
                        tbl_wr.txq      = txq_ff;
                        tbl_wr.chunk    = cfg.eff_min;
                     end
                  end
                  CMD_REQUEST: begin
                     if (!known_ff) begin
                        rsp_in.status = ST_UNKNOWN;
                     end else begin
                        tbl_wr.we_req = 1'b1;
                        tbl_wr.we_gr  = 1'b1;
                        tbl_wr.req    = count_ff;
                        if (!queued_ff[ent_ff] && (32'(wcnt_ff) < NUM_REMOTES)) begin
                           set_queued = 1'b1;
                           fifo_we    = 1'b1;
                           wcnt_in    = wcnt_ff + CW'(1);
                        end
                     end
                  end
                  CMD_REL_ONE: begin
                     if (!known_ff) begin
                        rsp_in.status = ST_UNKNOWN;
                     end else begin
                        if ((count_ff != 16'd0) && (tbl_rd.chunk < cfg.eff_max)) begin
                           chunk_nx = tbl_rd.chunk + 16'd1;
                        end else if (tbl_rd.chunk > cfg.eff_min) begin
                           chunk_nx = tbl_rd.chunk - 16'd1;
                        end
                        tbl_wr.we_chunk = 1'b1;
                        tbl_wr.chunk    = chunk_nx;
                        if (pool_ff != POOL_MAX) begin
                           pool_in = pool_ff + 16'd1;
                        end
                     end
                  end
                  CMD_REL_MANY: begin
                     pool_in = pool_sum[16] ? POOL_MAX : pool_sum[15:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DFIFO: begin
            state_in = S_DENT;
         end
         S_DENT: begin
            ent_in   = fifo_rd;
            state_in = S_DRD;
         end
         S_DRD: begin
            state_in = S_DEV;
         end
         S_DEV: begin
            tbl_wr.we_gr = ok;
            tbl_wr.gr    = tbl_rd.gr + 16'd1;
            pool_in      = pool_dec;
            moved_in     = moved_ff || ok;
            if ((pool_dec == 16'd0) || last_idx) begin
               idx_in = '0;
               if ((pool_dec != 16'd0) && (moved_ff || ok)) begin
                  moved_in = 1'b0;
                  state_in = S_DFIFO;
               end else begin
                  state_in = S_EFIFO;
               end
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_DFIFO;
            end
         end
         S_EFIFO: begin
            state_in = S_EENT;
         end
         S_EENT: begin
            ent_in   = fifo_rd;
            state_in = S_ERD;
         end
         S_ERD: begin
            state_in = S_EEV;
         end
         S_EEV: begin
            if (!has || !pend_valid_ff || out_free) begin
               if (has) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: ST_GRANT, remote_res: 5'(pend_ent_ff),
                                tx_queue_res: pend_txq_ff, granted: pend_gr_ff,
                                last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_ent_in   = ent_ff;
                  pend_txq_in   = tbl_rd.txq;
                  pend_gr_in    = tbl_rd.gr;
                  clr_queued    = 1'b1;
               end else begin
                  fifo_we    = 1'b1;
                  fifo_waddr = IW'(keep_ff);
                  keep_in    = keep_ff + CW'(1);
               end
               if (last_idx) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_EFIFO;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = '{status: ST_GRANT, remote_res: 5'(pend_ent_ff),
                             tx_queue_res: pend_txq_ff, granted: pend_gr_ff,
                             last: 1'b1};
               end else begin
                  rsp_in = '{status: ST_NONE, remote_res: 5'd0, tx_queue_res: 8'd0,
                             granted: 16'd0, last: 1'b1};
               end
               pend_valid_in = 1'b0;
               wcnt_in       = keep_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cfg.pool_load) begin
         pool_in = cfg.pool_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wcnt_ff       <= '0;
         keep_ff       <= '0;
         pool_ff       <= MAX_TOKENS_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_REMOTES; i++) begin
            valid_ff[i]  <= 1'b0;
            queued_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         wcnt_ff       <= wcnt_in;
         keep_ff       <= keep_in;
         pool_ff       <= pool_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (set_valid) begin
            valid_ff[ent_ff] <= 1'b1;
         end
         if (set_queued) begin
            queued_ff[ent_ff] <= 1'b1;
         end
         if (clr_queued) begin
            queued_ff[ent_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      txq_ff      <= txq_in;
      count_ff    <= count_in;
      inrange_ff  <= inrange_in;
      known_ff    <= known_in;
      ent_ff      <= ent_in;
      idx_ff      <= idx_in;
      moved_ff    <= moved_in;
      pend_ent_ff <= pend_ent_in;
      pend_txq_ff <= pend_txq_in;
      pend_gr_ff  <= pend_gr_in;
      rsp_ff      <= rsp_in;
   end

   `TCD_ASSERT_ALWAYS(a_wcnt_bound, (32'(wcnt_ff) <= NUM_REMOTES), "wait count overflow")
   `TCD_ASSERT_ALWAYS(a_keep_bound, (keep_ff <= wcnt_ff), "kept entries exceed queue")
   `TCD_ASSERT_NEXT(a_pool_dist, (state_ff == S_DEV), (pool_ff <= $past(pool_ff)), "pool grew in a pass")
   `TCD_ASSERT_ALWAYS(a_pend_idle, (state_ff != S_IDLE) || !pend_valid_ff, "grant left pending")

endmodule

@@ src/token_credit_distributor_unit.sv @@
// Init, request and release read the table, then act and register their result word.
// Distribute visits each queue slot with a queue read, entry latch, table read and
// evaluate over every pass, then again to emit grants; the memory reads are registered.
// Throughput: one command at a time; the next can be accepted in the cycle the last
// result word appears, and a stalled result word holds back the step that needs it.
// Reset: synchronous, clears the table valid and queued bits, empties the queue,
// restores the registers to their defaults and fills the pool with 64 tokens.
module token_credit_distributor_unit
   import tcd_pkg::*;
#(
   parameter int NUM_REMOTES = 32
) (
   input logic      clock,
   input logic      reset,
   tcd_req_if.sink  req_port,
   tcd_rsp_if.source rsp_port,
   tcd_csr_if.sink  csr_port
);

   logic [15:0] min_chunk_ff, min_chunk_in;
   logic [15:0] max_chunk_ff, max_chunk_in;
   logic [15:0] max_tokens_ff, max_tokens_in;
   cfg_type     cfg;
   rsp_type     rsp;
   logic        csr_fire;

   assign csr_port.ready = 1'b1;
   assign csr_fire = csr_port.valid;

   always_comb begin
      min_chunk_in  = min_chunk_ff;
      max_chunk_in  = max_chunk_ff;
      max_tokens_in = max_tokens_ff;
      cfg.pool_load  = 1'b0;
      cfg.pool_value = csr_port.data;
      if (csr_fire) begin
         case (csr_port.index)
            REG_MIN_CHUNK: begin
               min_chunk_in = csr_port.data;
            end
            REG_MAX_CHUNK: begin
               max_chunk_in = csr_port.data;
            end
            REG_MAX_TOKENS: begin
               max_tokens_in = csr_port.data;
               cfg.pool_load = 1'b1;
            end
            default: begin
            end
         endcase
      end
      cfg.eff_min = (min_chunk_ff == 16'd0) ? 16'd1 : min_chunk_ff;
      cfg.eff_max = (max_chunk_ff < max_tokens_ff) ? max_chunk_ff : max_tokens_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_chunk_ff  <= MIN_CHUNK_RESET;
         max_chunk_ff  <= MAX_CHUNK_RESET;
         max_tokens_ff <= MAX_TOKENS_RESET;
      end else begin
         min_chunk_ff  <= min_chunk_in;
         max_chunk_ff  <= max_chunk_in;
         max_tokens_ff <= max_tokens_in;
      end
   end

   tcd_ctrl #(.NUM_REMOTES(NUM_REMOTES)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_port.valid),
      .req_ready    (req_port.ready),
      .req_cmd      (req_port.cmd),
      .req_remote   (req_port.remote),
      .req_tx_queue (req_port.tx_queue),
      .req_count    (req_port.count),
      .rsp_valid    (rsp_port.valid),
      .rsp_ready    (rsp_port.ready),
      .rsp          (rsp)
   );

   assign rsp_port.status       = rsp.status;
   assign rsp_port.remote_res   = rsp.remote_res;
   assign rsp_port.tx_queue_res = rsp.tx_queue_res;
   assign rsp_port.granted      = rsp.granted;
   assign rsp_port.last         = rsp.last;

endmodule
